>>> hdl/c2cb_pkg.sv
// ----------------------------------------------------------------------------
// c2cb_pkg
// Shared types and constants of the 3x3 convolution and blend block.
// ----------------------------------------------------------------------------
package c2cb_pkg;

  localparam int NUM_TAPS  = 9;
  localparam int NUM_CHAN  = 4;
  localparam int CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_MID    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_RAD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_STR    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA = 3'd7;

  typedef logic [63:0] pix_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CAP,
    S_PICK,
    S_START,
    S_WAIT,
    S_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_TAP,
    L_DIFF,
    L_MLO,
    L_MHI,
    L_SUM,
    L_FIN
  } lane_phase_t;

  typedef struct packed {
    logic rd_en;
    logic we;
  } row_ctl_t;

endpackage

>>> hdl/conv2d_clamp_blend.sv
// ----------------------------------------------------------------------------
// conv2d_clamp_blend
// Streaming 3x3 convolution of RGBA pixels with replicated borders, blended
// against the original pixel; four channel lanes and one output stage.
// ----------------------------------------------------------------------------
// timing: a pixel transaction holds the block until each result it releases
//   is taken, a drain transaction until its result is taken, and an ignored
//   drain leaves it idle; each result waits in the output stage for out_ready
// flow: one item at a time; no new item is taken until the last is through
// reset: synchronous, clears counters, window and control; row stores are not
//   cleared and need no clearing pass
module conv2d_clamp_blend #(
  parameter int MAX_WIDTH   = 2048,
  parameter int KERNEL_SIZE = 3,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] red_in,
  input  logic [15:0] green_in,
  input  logic [15:0] blue_in,
  input  logic [15:0] alpha_in,
  input  logic        drain,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] red_out,
  output logic [15:0] green_out,
  output logic [15:0] blue_out,
  output logic [15:0] alpha_out,
  output logic        frame_done,
  output logic        last,
  input  logic        cfg_write,
  input  logic [c2cb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [47:0] cfg_data
);
  import c2cb_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [15:0] SMASK = 16'((32'd1 << SAMPLE_BITS) - 1);

  // configuration
  logic [47:0] coeff_reg [3];
  logic [11:0] image_width;
  logic [12:0] image_height;
  logic        kernel_radius;
  logic [16:0] blend_strength;
  logic        filter_alpha;

  top_state_t state, state_next;
  row_ctl_t   ctl;

  logic [AW-1:0] col, c_cur, x_cur, raddr, dcol;
  logic [11:0]   row, r_cur, hm1;
  logic [AW:0]   pending, w_eff;
  logic [AW-1:0] wm1;
  logic [12:0]   h_eff;
  logic [1:0]    k;
  logic          is_drain, want0, want1, fd_r, last_r;
  pix_t          pix, win [NUM_TAPS], loc [NUM_TAPS];
  pix_t          q_prev, q_older, top_pix;

  logic signed [15:0] coeff_eff [NUM_TAPS];
  logic [15:0]   samp [NUM_CHAN][NUM_TAPS];
  logic [15:0]   res  [NUM_CHAN];
  logic [NUM_CHAN-1:0] lane_done;
  logic          lane_start, radius;
  logic [16:0]   strength;
  logic [1:0]    pa, pb;

  always_comb begin
    if (image_width == 12'd0) begin
      w_eff = (AW+1)'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = (AW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (AW+1)'(image_width);
    end
    wm1 = AW'(w_eff - (AW+1)'(1));
    if (image_height == 13'd0) begin
      h_eff = 13'd1;
    end else if (image_height > 13'd4096) begin
      h_eff = 13'd4096;
    end else begin
      h_eff = image_height;
    end
    hm1 = 12'(h_eff - 13'd1);
    radius   = (KERNEL_SIZE >= 3) ? kernel_radius : 1'b0;
    strength = (blend_strength > 17'd65536) ? 17'd65536 : blend_strength;
  end

  // coefficients, non-center taps masked for the 1x1 kernel
  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      coeff_eff[i] = $signed(coeff_reg[i / 3][16 * (i % 3) +: 16]);
      if (!radius && i != 4) coeff_eff[i] = '0;
    end
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        samp[ch][i] = loc[i][16 * ch +: 16];
      end
    end
  end

  // neighbor column for a drain read
  always_comb begin
    dcol = x_cur;
    if (k == 2'd0 && x_cur != '0) dcol = x_cur - AW'(1);
    if (k == 2'd2 && x_cur < wm1) dcol = x_cur + AW'(1);
    raddr   = is_drain ? dcol : c_cur;
    top_pix = (r_cur == 12'd1) ? q_prev : q_older;
  end

  // window columns for the pick of a pixel result
  always_comb begin
    if (want0) begin
      pa = (c_cur == AW'(1)) ? 2'd1 : 2'd0;
      pb = 2'd1;
    end else begin
      pa = (c_cur == '0) ? 2'd2 : 2'd1;
      pb = 2'd2;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!drain || pending != '0) state_next = S_RD;
        end
      end
      S_RD: state_next = S_CAP;
      S_CAP: begin
        if (is_drain) begin
          state_next = (k == 2'd2) ? S_START : S_RD;
        end else if (r_cur != '0 && (c_cur != '0 || c_cur >= wm1)) begin
          state_next = S_PICK;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_PICK:  state_next = S_START;
      S_START: state_next = S_WAIT;
      S_WAIT:  if (&lane_done) state_next = S_OUT;
      S_OUT: begin
        if (out_ready) state_next = (want0 || want1) ? S_PICK : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == S_IDLE);
    out_valid  = (state == S_OUT);
    ctl.rd_en  = (state == S_RD);
    ctl.we     = (state == S_CAP) && !is_drain;
    lane_start = (state == S_START);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      coeff_reg[0]   <= '0;
      coeff_reg[1]   <= 48'd1073741824;
      coeff_reg[2]   <= '0;
      image_width    <= 12'd2048;
      image_height   <= 13'd2048;
      kernel_radius  <= 1'b1;
      blend_strength <= 17'd65536;
      filter_alpha   <= 1'b0;
      col            <= '0;
      row            <= '0;
      pending        <= '0;
      want0          <= 1'b0;
      want1          <= 1'b0;
      for (int i = 0; i < NUM_TAPS; i++) win[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_COEFF_TOP:    coeff_reg[0]   <= cfg_data;
          REG_COEFF_MID:    coeff_reg[1]   <= cfg_data;
          REG_COEFF_BOTTOM: coeff_reg[2]   <= cfg_data;
          REG_IMAGE_WIDTH:  image_width    <= cfg_data[11:0];
          REG_IMAGE_HEIGHT: image_height   <= cfg_data[12:0];
          REG_KERNEL_RAD:   kernel_radius  <= cfg_data[0];
          REG_BLEND_STR:    blend_strength <= cfg_data[16:0];
          REG_FILTER_ALPHA: filter_alpha   <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            is_drain <= drain;
            pix      <= {alpha_in & SMASK, blue_in & SMASK,
                         green_in & SMASK, red_in & SMASK};
            k        <= '0;
            x_cur    <= (col > wm1) ? wm1 : col;
            if (!drain) begin
              // a pixel while results are pending starts a new frame
              if (pending != '0) begin
                pending <= '0;
                c_cur   <= '0;
                r_cur   <= '0;
              end else begin
                c_cur <= col;
                r_cur <= row;
              end
            end
          end
        end
        S_CAP: begin
          if (is_drain) begin
            loc[k]     <= (hm1 != '0) ? q_older : q_prev;
            loc[3 + k] <= q_prev;
            loc[6 + k] <= q_prev;
            k          <= k + 2'd1;
            if (k == 2'd2) begin
              pending <= pending - (AW+1)'(1);
              col     <= (x_cur >= wm1) ? '0 : x_cur + AW'(1);
              fd_r    <= (pending == (AW+1)'(1));
              last_r  <= 1'b1;
            end
          end else begin
            for (int r = 0; r < 3; r++) begin
              win[r * 3]     <= win[r * 3 + 1];
              win[r * 3 + 1] <= win[r * 3 + 2];
            end
            win[2] <= top_pix;
            win[5] <= q_prev;
            win[8] <= pix;
            want0  <= (r_cur != '0) && (c_cur != '0);
            want1  <= (r_cur != '0) && (c_cur >= wm1);
            if (c_cur >= wm1) begin
              col <= '0;
              if (r_cur >= hm1) begin
                row     <= '0;
                pending <= w_eff;
              end else begin
                row <= r_cur + 12'd1;
              end
            end else begin
              col <= c_cur + AW'(1);
            end
          end
        end
        S_PICK: begin
          for (int r = 0; r < 3; r++) begin
            loc[r * 3]     <= win[r * 3 + 32'(pa)];
            loc[r * 3 + 1] <= win[r * 3 + 32'(pb)];
            loc[r * 3 + 2] <= win[r * 3 + 2];
          end
          fd_r <= 1'b0;
          if (want0) begin
            want0  <= 1'b0;
            last_r <= !want1;
          end else begin
            want1  <= 1'b0;
            last_r <= 1'b1;
          end
        end
        S_WAIT: begin
          // merge the lane results into the output register
          if (&lane_done) begin
            red_out    <= res[0];
            green_out  <= res[1];
            blue_out   <= res[2];
            alpha_out  <= filter_alpha ? res[3] : loc[4][63:48];
            frame_done <= fd_r;
            last       <= last_r;
          end
        end
        default: ;
      endcase
    end
  end

  c2cb_rows #(.AW(AW)) u_rows (
    .clk         (clk),
    .ctl         (ctl),
    .raddr       (raddr),
    .waddr       (c_cur),
    .wdata_prev  (pix),
    .wdata_older (q_prev),
    .q_prev      (q_prev),
    .q_older     (q_older)
  );

  for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_lane
    c2cb_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .start    (lane_start),
      .sample   (samp[ch]),
      .coeff    (coeff_eff),
      .orig     (loc[4][16 * ch +: 16]),
      .strength (strength),
      .smax     (SMASK),
      .done     (lane_done[ch]),
      .result   (res[ch])
    );
  end

endmodule

>>> hdl/c2cb_lane.sv
// ----------------------------------------------------------------------------
// c2cb_lane
// One channel: nine-tap multiply accumulate, then blend, round and clamp.
// ----------------------------------------------------------------------------
module c2cb_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        sample [c2cb_pkg::NUM_TAPS],
  input  logic signed [15:0] coeff  [c2cb_pkg::NUM_TAPS],
  input  logic [15:0]        orig,
  input  logic [16:0]        strength,
  input  logic [15:0]        smax,
  output logic               done,
  output logic [15:0]        result
);
  import c2cb_pkg::*;

  lane_phase_t       phase, phase_next;
  logic [3:0]        tap;
  logic signed [35:0] acc;
  logic signed [36:0] diff;
  logic [35:0]       plo;
  logic signed [35:0] phi;
  logic signed [32:0] prod;
  logic signed [55:0] t_orig, t_hi, t_lo, tot;
  logic [25:0]       v;

  assign prod = $signed(coeff[tap]) * $signed({1'b0, sample[tap]});

  always_comb begin
    phase_next = phase;
    unique case (phase)
      L_IDLE: if (start) phase_next = L_TAP;
      L_TAP:  if (tap == 4'(NUM_TAPS - 1)) phase_next = L_DIFF;
      L_DIFF: phase_next = L_MLO;
      L_MLO:  phase_next = L_MHI;
      L_MHI:  phase_next = L_SUM;
      L_SUM:  phase_next = L_FIN;
      L_FIN:  phase_next = L_IDLE;
      default: phase_next = L_IDLE;
    endcase
  end

  always_comb begin
    done = (phase == L_FIN);
  end

  // orig*2^30 + strength*diff + half, with the product split at bit 19
  always_comb begin
    t_orig = 56'($signed({1'b0, orig, 30'd0}));
    t_hi   = 56'(phi) <<< 19;
    t_lo   = 56'($signed({1'b0, plo}));
    tot    = t_orig + t_hi + t_lo + 56'sd536870912;
    v      = tot[55:30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= L_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      L_IDLE: begin
        acc <= '0;
        tap <= '0;
      end
      L_TAP: begin
        acc <= acc + 36'(prod);
        tap <= tap + 4'd1;
      end
      L_DIFF: diff <= 37'(acc) - 37'($signed({1'b0, orig, 14'd0}));
      L_MLO:  plo <= strength * diff[18:0];
      L_MHI:  phi <= $signed({1'b0, strength}) * $signed(diff[36:19]);
      L_SUM: begin
        if (tot[55]) begin
          result <= '0;
        end else if (v > {10'd0, smax}) begin
          result <= smax;
        end else begin
          result <= v[15:0];
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/c2cb_rows.sv
// ----------------------------------------------------------------------------
// c2cb_rows
// Line stores for the previous row and the row before it.
// ----------------------------------------------------------------------------
module c2cb_rows #(
  parameter int AW = 11
) (
  input  logic                clk,
  input  c2cb_pkg::row_ctl_t  ctl,
  input  logic [AW-1:0]       raddr,
  input  logic [AW-1:0]       waddr,
  input  c2cb_pkg::pix_t      wdata_prev,
  input  c2cb_pkg::pix_t      wdata_older,
  output c2cb_pkg::pix_t      q_prev,
  output c2cb_pkg::pix_t      q_older
);
  import c2cb_pkg::*;

  pix_t mem_prev  [2**AW];
  pix_t mem_older [2**AW];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem_prev[waddr]  <= wdata_prev;
      mem_older[waddr] <= wdata_older;
    end
    if (ctl.rd_en) begin
      q_prev  <= mem_prev[raddr];
      q_older <= mem_older[raddr];
    end
  end

endmodule
